@@ rtl/tank_level_fill_timer_macros.svh @@
// Assertion macros shared by the tank level fill timer checker.
`ifndef TANK_LEVEL_FILL_TIMER_MACROS_SVH
`define TANK_LEVEL_FILL_TIMER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TLFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlft: %s failed", "label");

// Next-cycle implication, disabled while in reset.
`define TLFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlft: %s failed", "label");

`endif

@@ rtl/tlft_pkg.sv @@
// Types and constants for the tank level fill timer.
package tlft_pkg;

    localparam int THR_W  = 12;
    localparam int MODE_W = 3;
    localparam int CFG_W  = 12;
    localparam int TIME_W = 16;
    localparam int SUM_W  = 32;
    localparam int DVD_W  = 32;
    localparam int DVS_W  = 16;
    localparam int MUL_W  = 23;

    localparam logic [0:0] REG_PUMPING_MODE  = 1'b0;
    localparam logic [0:0] REG_WET_THRESHOLD = 1'b1;

    localparam logic [MODE_W-1:0] MODE_SUPPLY     = 3'd2;
    localparam logic [THR_W-1:0]  THR_RESET       = 12'd1000;
    localparam logic [TIME_W-1:0] PROG_FULL       = 16'd100;
    localparam logic [TIME_W-1:0] PROG_EMPTY      = 16'd0;
    localparam logic [TIME_W-1:0] PROG_FLAT       = 16'd50;
    localparam logic [TIME_W-1:0] AVG_MIN         = 16'd10;
    localparam logic [TIME_W-1:0] U16_MAX         = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_UNKNOWN = 3'd0,
        ST_FULL    = 3'd1,
        ST_DRAIN   = 3'd2,
        ST_FILL    = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_ERROR   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_FULL  = 2'd1,
        EV_EMPTY = 2'd2
    } evt_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_DIV,
        SEQ_PUSH
    } seq_state_t;

    typedef enum logic [1:0] {
        TGT_FILL_AVG,
        TGT_DRAIN_AVG,
        TGT_PROGRESS
    } div_tgt_t;

endpackage

@@ rtl/tlft_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
module tlft_div import tlft_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W:0]   rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W:0]   rem_shift;
    logic [DVS_W:0]   rem_diff;
    logic             fits;

    assign rem_shift = {rem_reg[DVS_W-1:0], quo_reg[DVD_W-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? rem_diff : rem_shift;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/tank_level_fill_timer.sv @@
// Tank level fill timer top level: classifier, interval timers and sequencer.
//
// Usage:
//   One request per sensor tick on the input channel (in_valid/in_ready)
//   carries the low and high level sensor samples. One result per request
//   leaves on the output channel (out_valid/out_ready): level status and
//   held progress. Registers are written on cfg_we (index 0 pumping mode,
//   index 1 wet threshold); the user must do so only while the block is
//   idle, as the block itself does not enforce it. A request that needs
//   no division goes straight from the idle state to the push state. One
//   that closes an interval (sum / count) or updates progress from a timer
//   (time*100 / average) first waits in the divide state: one shared
//   restoring divider yields one quotient bit per cycle, raises done, and
//   its quotient is written back before the push. One request at a time:
//   in_ready is high in the idle state only.
//   The result sits in an output register; a new request is taken while
//   it waits. If the receiver stalls, a finished result waits in the
//   sequencer until the output register frees up.
//   Reset: mode 2, threshold 1000, all timers, sums, counts, averages and
//   progress cleared, no full or empty event seen yet.
module tank_level_fill_timer import tlft_pkg::*;
#(
    parameter int ADC_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ADC_BITS-1:0] low_sensor_adc,
    input  logic [ADC_BITS-1:0] high_sensor_adc,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          level_status,
    output logic [15:0]         progress
);

    localparam int CW = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;

    // configuration
    logic [MODE_W-1:0] mode_reg;
    logic [THR_W-1:0]  thr_reg;

    // sequencer
    seq_state_t state_reg, state_next;
    div_tgt_t   tgt_reg, tgt_next;
    status_t    pend_status_reg, pend_status_next;

    // tank state
    status_t           prev_status_reg, prev_status_next;
    evt_t              last_event_reg, last_event_next;
    logic [TIME_W-1:0] progress_reg, progress_next;
    logic [TIME_W-1:0] fill_time_reg, fill_time_next;
    logic [SUM_W-1:0]  fill_sum_reg, fill_sum_next;
    logic [TIME_W-1:0] fill_count_reg, fill_count_next;
    logic [TIME_W-1:0] fill_avg_reg, fill_avg_next;
    logic [TIME_W-1:0] drain_time_reg, drain_time_next;
    logic [SUM_W-1:0]  drain_sum_reg, drain_sum_next;
    logic [TIME_W-1:0] drain_count_reg, drain_count_next;
    logic [TIME_W-1:0] drain_avg_reg, drain_avg_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    status_t           level_status_reg;
    logic [TIME_W-1:0] progress_out_reg;

    // control
    logic accept, need_div, div_start, div_done, push, out_free;

    // datapath
    logic [CW-1:0]     thr_c;
    logic              lo_wet, hi_wet;
    logic [TIME_W-1:0] fill_time_inc, drain_time_inc;
    logic [TIME_W-1:0] fill_count_inc, drain_count_inc;
    logic [SUM_W:0]    fill_sum_raw, drain_sum_raw;
    logic [SUM_W-1:0]  fill_sum_sat, drain_sum_sat;
    logic [MUL_W-1:0]  fill_mul, drain_mul;
    logic [DVD_W-1:0]  div_dividend, div_quotient;
    logic [DVS_W-1:0]  div_divisor;
    logic [TIME_W-1:0] quo_sat;

    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SUPPLY;
            thr_reg  <= THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PUMPING_MODE:  mode_reg <= cfg_data[MODE_W-1:0];
                REG_WET_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                default:           mode_reg <= mode_reg;
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                    state_next = need_div ? SEQ_DIV : SEQ_PUSH;
            end
            SEQ_DIV:
            begin
                if (div_done)
                    state_next = SEQ_PUSH;
            end
            SEQ_PUSH:
            begin
                if (out_free)
                    state_next = SEQ_IDLE;
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        push      = 1'b0;
        case (state_reg)
            SEQ_IDLE: in_ready = 1'b1;
            SEQ_PUSH: push     = out_free;
            default:  in_ready = 1'b0;
        endcase
        div_start = accept && need_div;
    end

    // wet detection, threshold taken in its low ADC_BITS
    assign thr_c  = CW'(thr_reg) & CW'({ADC_BITS{1'b1}});
    assign lo_wet = CW'(low_sensor_adc) <= thr_c;
    assign hi_wet = CW'(high_sensor_adc) <= thr_c;

    // saturating timers, counts and sums
    assign fill_time_inc   = (fill_time_reg == U16_MAX) ? U16_MAX : fill_time_reg + 1'b1;
    assign drain_time_inc  = (drain_time_reg == U16_MAX) ? U16_MAX : drain_time_reg + 1'b1;
    assign fill_count_inc  = (fill_count_reg == U16_MAX) ? U16_MAX : fill_count_reg + 1'b1;
    assign drain_count_inc = (drain_count_reg == U16_MAX) ? U16_MAX
                                                          : drain_count_reg + 1'b1;
    assign fill_sum_raw    = {1'b0, fill_sum_reg} + (SUM_W + 1)'(fill_time_reg);
    assign drain_sum_raw   = {1'b0, drain_sum_reg} + (SUM_W + 1)'(drain_time_reg);
    assign fill_sum_sat    = fill_sum_raw[SUM_W] ? '1 : fill_sum_raw[SUM_W-1:0];
    assign drain_sum_sat   = drain_sum_raw[SUM_W] ? '1 : drain_sum_raw[SUM_W-1:0];

    // time * 100 as shifts: 64 + 32 + 4
    assign fill_mul  = (MUL_W'(fill_time_inc) << 6) + (MUL_W'(fill_time_inc) << 5)
                     + (MUL_W'(fill_time_inc) << 2);
    assign drain_mul = (MUL_W'(drain_time_inc) << 6) + (MUL_W'(drain_time_inc) << 5)
                     + (MUL_W'(drain_time_inc) << 2);

    assign quo_sat = (div_quotient[DVD_W-1:TIME_W] != '0) ? U16_MAX
                                                          : div_quotient[TIME_W-1:0];

    // tank state update
    always_comb
    begin
        prev_status_next = prev_status_reg;
        last_event_next  = last_event_reg;
        progress_next    = progress_reg;
        fill_time_next   = fill_time_reg;
        fill_sum_next    = fill_sum_reg;
        fill_count_next  = fill_count_reg;
        fill_avg_next    = fill_avg_reg;
        drain_time_next  = drain_time_reg;
        drain_sum_next   = drain_sum_reg;
        drain_count_next = drain_count_reg;
        drain_avg_next   = drain_avg_reg;
        pend_status_next = pend_status_reg;
        tgt_next         = tgt_reg;
        need_div         = 1'b0;
        div_dividend     = DVD_W'(fill_mul);
        div_divisor      = fill_avg_reg;

        if (accept)
        begin
            pend_status_next = ST_UNKNOWN;
            if (mode_reg == MODE_SUPPLY)
            begin
                if (lo_wet && hi_wet)
                begin
                    pend_status_next = ST_FULL;
                    prev_status_next = ST_FULL;
                    if (prev_status_reg != ST_FULL)
                    begin
                        last_event_next = EV_FULL;
                        fill_sum_next   = fill_sum_sat;
                        fill_count_next = fill_count_inc;
                        fill_time_next  = '0;
                        progress_next   = PROG_FULL;
                        need_div        = 1'b1;
                        tgt_next        = TGT_FILL_AVG;
                        div_dividend    = fill_sum_sat;
                        div_divisor     = fill_count_inc;
                    end
                end
                else if (lo_wet)
                begin
                    prev_status_next = ST_UNKNOWN;
                    if (last_event_reg == EV_FULL)
                    begin
                        pend_status_next = ST_DRAIN;
                        prev_status_next = ST_DRAIN;
                        drain_time_next  = drain_time_inc;
                        tgt_next         = TGT_PROGRESS;
                        div_dividend     = DVD_W'(drain_mul);
                        div_divisor      = drain_avg_reg;
                        if (drain_avg_reg > AVG_MIN)
                            need_div = 1'b1;
                        else
                            progress_next = PROG_FLAT;
                    end
                    else if (last_event_reg == EV_EMPTY)
                    begin
                        pend_status_next = ST_FILL;
                        prev_status_next = ST_FILL;
                        fill_time_next   = fill_time_inc;
                        tgt_next         = TGT_PROGRESS;
                        div_dividend     = DVD_W'(fill_mul);
                        div_divisor      = fill_avg_reg;
                        if (fill_avg_reg > AVG_MIN)
                            need_div = 1'b1;
                        else
                            progress_next = PROG_FLAT;
                    end
                end
                else if (!hi_wet)
                begin
                    pend_status_next = ST_EMPTY;
                    prev_status_next = ST_EMPTY;
                    if (prev_status_reg != ST_EMPTY)
                    begin
                        last_event_next  = EV_EMPTY;
                        drain_sum_next   = drain_sum_sat;
                        drain_count_next = drain_count_inc;
                        drain_time_next  = '0;
                        progress_next    = PROG_EMPTY;
                        need_div         = 1'b1;
                        tgt_next         = TGT_DRAIN_AVG;
                        div_dividend     = drain_sum_sat;
                        div_divisor      = drain_count_inc;
                    end
                end
                else
                begin
                    // high wet with low dry: sensor fault, state untouched
                    pend_status_next = ST_ERROR;
                end
            end
        end

        if (state_reg == SEQ_DIV && div_done)
        begin
            case (tgt_reg)
                TGT_FILL_AVG:  fill_avg_next  = quo_sat;
                TGT_DRAIN_AVG: drain_avg_next = quo_sat;
                TGT_PROGRESS:  progress_next  = quo_sat;
                default:       progress_next  = progress_reg;
            endcase
        end
    end

    assign out_valid_next = push ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= SEQ_IDLE;
            tgt_reg         <= TGT_FILL_AVG;
            pend_status_reg <= ST_UNKNOWN;
            prev_status_reg <= ST_UNKNOWN;
            last_event_reg  <= EV_NONE;
            progress_reg    <= '0;
            fill_time_reg   <= '0;
            fill_sum_reg    <= '0;
            fill_count_reg  <= '0;
            fill_avg_reg    <= '0;
            drain_time_reg  <= '0;
            drain_sum_reg   <= '0;
            drain_count_reg <= '0;
            drain_avg_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            tgt_reg         <= tgt_next;
            pend_status_reg <= pend_status_next;
            prev_status_reg <= prev_status_next;
            last_event_reg  <= last_event_next;
            progress_reg    <= progress_next;
            fill_time_reg   <= fill_time_next;
            fill_sum_reg    <= fill_sum_next;
            fill_count_reg  <= fill_count_next;
            fill_avg_reg    <= fill_avg_next;
            drain_time_reg  <= drain_time_next;
            drain_sum_reg   <= drain_sum_next;
            drain_count_reg <= drain_count_next;
            drain_avg_reg   <= drain_avg_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            level_status_reg <= pend_status_reg;
            progress_out_reg <= progress_reg;
        end
    end

    tlft_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_valid    = out_valid_reg;
    assign level_status = level_status_reg;
    assign progress     = progress_out_reg;

endmodule

@@ rtl/tlft_checker.sv @@
// Port-level checker for the tank level fill timer, bound to the top level.
`include "tank_level_fill_timer_macros.svh"

module tlft_checker import tlft_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  level_status,
    input logic [15:0] progress
);

    // a stalled result holds
    `TLFT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(level_status) && $stable(progress))

    // one request at a time: ready drops right after a request is taken
    `TLFT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // full always shows 100 percent
    `TLFT_ASSERT_IMPL(a_full_progress, clk, rst_n, out_valid && level_status == ST_FULL,
        progress == PROG_FULL)

    // empty always shows zero
    `TLFT_ASSERT_IMPL(a_empty_progress, clk, rst_n, out_valid && level_status == ST_EMPTY,
        progress == PROG_EMPTY)

endmodule

bind tank_level_fill_timer tlft_checker u_tlft_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .level_status (level_status),
    .progress     (progress)
);

@@ verif/tank_level_fill_timer_tb.sv @@
// Self-checking testbench for the tank level fill timer: random handshakes, predictor, scoreboard.
`timescale 1ns / 1ps

module tank_level_fill_timer_tb;
    import tlft_pkg::*;

    localparam logic [11:0] ADC_MAX     = 12'hFFF;
    localparam logic [2:0]  MODE_OFF    = 3'd0;
    localparam logic [2:0]  MODE_ALT3   = 3'd3;
    localparam logic [2:0]  MODE_ALT6   = 3'd6;
    localparam logic [2:0]  MODE_MAX    = 3'd7;
    localparam int          SETTLE      = 40;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          LONG_FILL   = 300;

    typedef struct packed {
        logic [15:0] ticks;
        logic [31:0] total;
        logic [15:0] laps;
        logic [15:0] mean;
    } leg_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] level;
    } report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [11:0] low_sensor_adc = '0;
    logic [11:0] high_sensor_adc = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  level_status;
    logic [15:0] progress;

    // model of the block
    logic [2:0]  cur_mode = MODE_SUPPLY;
    logic [11:0] cur_thr = THR_RESET;
    status_t     prev_status = ST_UNKNOWN;
    evt_t        last_evt = EV_NONE;
    logic [15:0] held_level = '0;
    leg_t        fill_leg = '0;
    leg_t        drain_leg = '0;

    logic [23:0] sample_queue[$];
    report_t     pending_reports[$];
    report_t     want;
    logic [23:0] next_pair;
    int          ticks_queued = 0;
    int          ticks_taken = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    bit          req_taken = 1'b0;
    bit          calm = 1'b0;

    tank_level_fill_timer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .low_sensor_adc  (low_sensor_adc),
        .high_sensor_adc (high_sensor_adc),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .level_status    (level_status),
        .progress        (progress)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // interval closes on a full or empty event: running sum / count
    function automatic void close_leg(inout leg_t leg);
        logic [32:0] acc;
        logic [31:0] quot;
        acc = {1'b0, leg.total} + {17'd0, leg.ticks};
        leg.total = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
        if (leg.laps != U16_MAX)
            leg.laps = leg.laps + 16'd1;
        quot = leg.total / {16'd0, leg.laps};
        leg.mean = (quot > {16'd0, U16_MAX}) ? U16_MAX : quot[15:0];
        leg.ticks = '0;
    endfunction

    function automatic logic [15:0] advance_leg(inout leg_t leg);
        logic [31:0] pct;
        if (leg.ticks != U16_MAX)
            leg.ticks = leg.ticks + 16'd1;
        if (leg.mean > AVG_MIN)
        begin
            pct = ({16'd0, leg.ticks} * 32'd100) / {16'd0, leg.mean};
            return (pct > {16'd0, U16_MAX}) ? U16_MAX : pct[15:0];
        end
        return PROG_FLAT;
    endfunction

    function automatic report_t classify_tick(input logic [11:0] lo, input logic [11:0] hi);
        report_t r;
        logic    lo_wet;
        logic    hi_wet;
        lo_wet = lo <= cur_thr;
        hi_wet = hi <= cur_thr;
        r.status = ST_UNKNOWN;
        if (cur_mode == MODE_SUPPLY)
        begin
            if (lo_wet && hi_wet)
            begin
                r.status = ST_FULL;
                if (prev_status != ST_FULL)
                begin
                    last_evt = EV_FULL;
                    close_leg(fill_leg);
                    held_level = PROG_FULL;
                end
                prev_status = r.status;
            end
            else if (lo_wet)
            begin
                if (last_evt == EV_FULL)
                begin
                    r.status = ST_DRAIN;
                    held_level = advance_leg(drain_leg);
                end
                else if (last_evt == EV_EMPTY)
                begin
                    r.status = ST_FILL;
                    held_level = advance_leg(fill_leg);
                end
                prev_status = r.status;
            end
            else if (!hi_wet)
            begin
                r.status = ST_EMPTY;
                if (prev_status != ST_EMPTY)
                begin
                    last_evt = EV_EMPTY;
                    close_leg(drain_leg);
                    held_level = PROG_EMPTY;
                end
                prev_status = r.status;
            end
            else
            begin
                r.status = ST_ERROR;
            end
        end
        r.level = held_level;
        return r;
    endfunction

    function automatic logic [11:0] wet_adc();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return cur_thr;
        return 12'($urandom_range(0, cur_thr));
    endfunction

    function automatic logic [11:0] dry_adc();
        int pick;
        if (cur_thr == ADC_MAX)
            return ADC_MAX;
        pick = $urandom_range(0, 5);
        if (pick == 0)
            return cur_thr + 12'd1;
        if (pick == 1)
            return ADC_MAX;
        return 12'($urandom_range(cur_thr + 12'd1, ADC_MAX));
    endfunction

    task automatic queue_tick(input logic [11:0] lo, input logic [11:0] hi);
        sample_queue.push_back({lo, hi});
        ticks_queued++;
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [11:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_PUMPING_MODE)
            cur_mode = val[2:0];
        else
            cur_thr = val;
    endtask

    task automatic wait_idle();
        while (ticks_taken != ticks_queued || pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // legs in order: empty, filling, full, draining; some noise and skipped legs
    task automatic queue_cycles(input int count);
        int added;
        int seg;
        int span;
        added = 0;
        seg = 0;
        while (added < count)
        begin
            if (seg == 0 || seg == 2)
                span = $urandom_range(1, 3);
            else if ($urandom_range(0, 4) == 0)
                span = $urandom_range(12, 40);
            else
                span = $urandom_range(1, 12);
            if ($urandom_range(0, 9) != 0)
            begin
                repeat (span)
                begin
                    if ($urandom_range(0, 9) == 0)
                        queue_tick(12'($urandom_range(0, ADC_MAX)),
                                   12'($urandom_range(0, ADC_MAX)));
                    else if (seg == 0)
                        queue_tick(dry_adc(), dry_adc());
                    else if (seg == 2)
                        queue_tick(wet_adc(), wet_adc());
                    else
                        queue_tick(wet_adc(), dry_adc());
                    added++;
                end
            end
            seg = (seg + 1) % 4;
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || req_taken)
        begin
            req_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 11);
                in_valid <= 1'b0;
            end
            else if (sample_queue.size() > 0)
            begin
                next_pair = sample_queue.pop_front();
                low_sensor_adc <= next_pair[23:12];
                high_sensor_adc <= next_pair[11:0];
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!hold_done && results_seen >= 100)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // scoreboard, prediction on accepted requests, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_reports.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: status %0d progress %0d",
                                 level_status, progress);
                    mismatches++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (level_status !== want.status || progress !== want.level)
                    begin
                        if (mismatches < 10)
                            $display({"mismatch at result %0d: status exp %0d got %0d,",
                                      " progress exp %0d got %0d"},
                                     results_seen, want.status, level_status, want.level,
                                     progress);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                pending_reports.push_back(classify_tick(low_sensor_adc, high_sensor_adc));
                ticks_taken++;
                req_taken = 1'b1;
            end
            if ((out_valid && out_ready) || (in_valid && in_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int lap_ticks;
        int count;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: no event yet, sensor error, threshold edges, every status
        queue_tick(12'd1000, ADC_MAX);
        queue_tick(ADC_MAX, 12'd0);
        queue_tick(12'd0, 12'd1000);
        queue_tick(12'd999, 12'd999);
        repeat (3) queue_tick(12'd1000, 12'd1001);
        queue_tick(12'd1001, ADC_MAX);
        queue_tick(ADC_MAX, ADC_MAX);
        repeat (3) queue_tick(12'd0, ADC_MAX);
        queue_tick(ADC_MAX, 12'd1000);
        queue_tick(12'd0, 12'd0);
        wait_idle();

        // inactive modes report unknown and leave state alone
        write_reg(REG_PUMPING_MODE, {9'd0, MODE_OFF});
        queue_tick(12'd0, 12'd0);
        queue_tick(ADC_MAX, ADC_MAX);
        wait_idle();
        write_reg(REG_PUMPING_MODE, {9'd0, MODE_MAX});
        queue_tick(ADC_MAX, 12'd0);
        queue_tick(12'd0, ADC_MAX);
        wait_idle();
        write_reg(REG_PUMPING_MODE, {9'd0, MODE_SUPPLY});
        write_reg(REG_WET_THRESHOLD, THR_RESET);

        // pull the fill average to just above the flat-progress limit, then fill
        // long enough for progress to climb far past 100 percent
        lap_ticks = (int'(AVG_MIN) + 1) * (int'(fill_leg.laps) + 1)
                    - int'(fill_leg.total) - int'(fill_leg.ticks);
        if (lap_ticks < 1)
            lap_ticks = 1;
        queue_tick(ADC_MAX, ADC_MAX);
        repeat (lap_ticks) queue_tick(12'd0, ADC_MAX);
        queue_tick(12'd0, 12'd0);
        queue_tick(12'd0, ADC_MAX);
        queue_tick(ADC_MAX, ADC_MAX);
        repeat (LONG_FILL) queue_tick(wet_adc(), dry_adc());
        queue_tick(12'd0, 12'd0);
        wait_idle();

        // random phases across settings; the last one runs with no random request gaps or receiver stalls
        for (int p = 0; p < 10; p++)
        begin
            case (p)
                3:       write_reg(REG_PUMPING_MODE, {9'd0, MODE_ALT6});
                6:       write_reg(REG_PUMPING_MODE, {9'd0, MODE_ALT3});
                default: write_reg(REG_PUMPING_MODE, {9'd0, MODE_SUPPLY});
            endcase
            case (p)
                1:       write_reg(REG_WET_THRESHOLD, 12'd0);
                2:       write_reg(REG_WET_THRESHOLD, ADC_MAX);
                4:       write_reg(REG_WET_THRESHOLD, 12'd1);
                5:       write_reg(REG_WET_THRESHOLD, ADC_MAX - 12'd1);
                9:       write_reg(REG_WET_THRESHOLD, THR_RESET);
                default: write_reg(REG_WET_THRESHOLD,
                                   12'($urandom_range(1, ADC_MAX - 12'd1)));
            endcase
            count = (cur_mode == MODE_SUPPLY) ? 140 : 40;
            if (p == 9)
                calm = 1'b1;
            queue_cycles(count);
            wait_idle();
        end

        if (mismatches == 0 && pending_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
